/* design/bfa_pkg.sv */
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and fixed widths of the bitmap frame allocator.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int CNT_W  = 16;    // frame count and register width
    localparam int ADDR_W = 32;    // byte address and region length width

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_FREE    = 2'd1,
        REQ_RELEASE = 2'd2,
        REQ_RESERVE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_OOM   = 2'd1,
        STS_RANGE = 2'd2
    } t_status;

    // Operation of the shared word unit
    typedef enum logic [1:0] {
        WOP_SCAN,
        WOP_SET,
        WOP_CLR
    } t_word_op;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_MOD,
        ST_DONE
    } t_state;

endpackage

/* design/bfa_if.sv */
// ----------------------------------------------------------------------------
// bfa_req_if / bfa_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface bfa_req_if import bfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] byte_address;
    logic [ADDR_W-1:0] region_bytes;

    modport source (output valid, output req_type, output byte_address,
                    output region_bytes, input ready);
    modport sink   (input valid, input req_type, input byte_address,
                    input region_bytes, output ready);
endinterface

interface bfa_rsp_if import bfa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] frame_address;
    logic [CNT_W-1:0]  free_frames;
    logic [CNT_W-1:0]  used_frames;

    modport source (output valid, output status, output frame_address,
                    output free_frames, output used_frames, input ready);
    modport sink   (input valid, input status, input frame_address,
                    input free_frames, input used_frames, output ready);
endinterface

/* design/bfa_map_ram.sv */
// ----------------------------------------------------------------------------
// bfa_map_ram
// One-port-write, one-port-read memory holding the used bitmap words.
// ----------------------------------------------------------------------------
module bfa_map_ram #(
    parameter int WORDS  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [WORDS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/bfa_word_unit.sv */
// ----------------------------------------------------------------------------
// bfa_word_unit
// Shared word unit: sets or clears a frame range inside one map word, or
// takes the lowest free bit; reports the number of bits that flipped.
// ----------------------------------------------------------------------------
module bfa_word_unit import bfa_pkg::*; #(
    parameter int MAP_WORD_BITS = 32,
    parameter int KW            = 16
) (
    input  t_word_op                             i_op,
    input  logic [MAP_WORD_BITS-1:0]             i_old,
    input  logic [KW-1:0]                        i_base,
    input  logic [CNT_W-1:0]                     i_first,
    input  logic [CNT_W-1:0]                     i_end,
    output logic [MAP_WORD_BITS-1:0]             o_new,
    output logic [$clog2(MAP_WORD_BITS+1)-1:0]   o_flips,
    output logic                                 o_found,
    output logic [$clog2(MAP_WORD_BITS)-1:0]     o_bit
);

    localparam int PW  = $clog2(MAP_WORD_BITS + 1);
    localparam int BIW = $clog2(MAP_WORD_BITS);

    logic [KW-1:0]            first_k;
    logic [KW-1:0]            end_k;
    logic [KW-1:0]            diff_lo;
    logic [KW-1:0]            diff_hi;
    logic [PW-1:0]            lo;
    logic [PW-1:0]            hi;
    logic [MAP_WORD_BITS-1:0] mask;

    assign first_k = KW'(i_first);
    assign end_k   = KW'(i_end);
    assign diff_lo = first_k - i_base;
    assign diff_hi = end_k - i_base;

    always_comb begin
        // Range offsets inside this word, clipped to [0, word bits]
        if (first_k <= i_base) begin
            lo = '0;
        end else if (diff_lo >= KW'(MAP_WORD_BITS)) begin
            lo = PW'(MAP_WORD_BITS);
        end else begin
            lo = PW'(diff_lo);
        end
        if (end_k <= i_base) begin
            hi = '0;
        end else if (diff_hi >= KW'(MAP_WORD_BITS)) begin
            hi = PW'(MAP_WORD_BITS);
        end else begin
            hi = PW'(diff_hi);
        end

        for (int j = 0; j < MAP_WORD_BITS; j++) begin
            mask[j] = (PW'(j) >= lo) && (PW'(j) < hi);
        end

        // Lowest zero bit
        o_found = 1'b0;
        o_bit   = '0;
        for (int j = MAP_WORD_BITS - 1; j >= 0; j--) begin
            if (!i_old[j]) begin
                o_found = 1'b1;
                o_bit   = BIW'(j);
            end
        end

        case (i_op)
            WOP_SET: o_new = i_old | mask;
            WOP_CLR: o_new = i_old & ~mask;
            WOP_SCAN: begin
                o_new = i_old;
                if (o_found) begin
                    o_new[o_bit] = 1'b1;
                end
            end
            default: o_new = i_old;
        endcase

        o_flips = PW'($countones(o_new ^ i_old));
    end

endmodule

/* design/bitmap_frame_allocator.sv */
// A free or a region in range passes ST_DIV, then a read and a modify step per map word it
//   covers (plus word 0 again for the frame 0 pin after a release); alloc reads and modifies
//   each map word from the lowest word that may hold a free frame, else goes to ST_DONE.
// Items are taken one at a time; each map word takes a read step and a modify step
//   through the bitmap memory and the shared word unit.
// Reset and each total_frames write start a fill pass over all MAP_WORDS words (1024 at
//   defaults) that marks every frame used; no item is accepted during the pass.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit page frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator import bfa_pkg::*; #(
    parameter int MAX_FRAMES    = 32768,
    parameter int PAGE_SHIFT    = 12,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    bfa_req_if.sink          i_req,
    bfa_rsp_if.source        o_rsp
);

    // ------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------
    localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WIW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIW       = $clog2(MAP_WORD_BITS);
    localparam int PW        = $clog2(MAP_WORD_BITS + 1);
    localparam int FXW       = $clog2(MAP_WORDS * MAP_WORD_BITS);
    localparam int KW        = (FXW > CNT_W) ? FXW : CNT_W;     // frame number width
    localparam int AW        = ADDR_W - PAGE_SHIFT;             // frame bits of an address
    localparam int CW        = ((AW > CNT_W) ? AW : CNT_W) + 1; // request compare width
    // Exact floor(first / MAP_WORD_BITS) for a CNT_W-bit first by a ceiling reciprocal
    localparam int RL        = $clog2(MAP_WORD_BITS);
    localparam int RS        = CNT_W + RL;
    localparam longint RM    = ((64'd1 << RS) + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int PRW       = CNT_W + RS + 1 + WIW;
    localparam logic [WIW-1:0] LAST_WORD = WIW'(MAP_WORDS - 1);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state           r_state,  n_state;
    logic [WIW-1:0]   r_word,   n_word;     // current map word
    logic [WIW-1:0]   r_hint,   n_hint;     // every word below is full
    logic [KW-1:0]    r_base,   n_base;     // first frame of r_word
    logic [CNT_W-1:0] r_first,  n_first;    // range start frame
    logic [CNT_W-1:0] r_end,    n_end;      // range end frame, exclusive
    t_word_op         r_op,     n_op;
    logic             r_pin,    n_pin;      // re-reserve frame 0 after the walk
    t_status          r_status, n_status;
    logic [ADDR_W-1:0] r_faddr, n_faddr;
    logic [CNT_W-1:0] r_total,  n_total;
    logic [CNT_W-1:0] r_used,   n_used;

    logic              r_out_valid,  n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [ADDR_W-1:0] r_out_faddr,  n_out_faddr;
    logic [CNT_W-1:0]  r_out_free,   n_out_free;
    logic [CNT_W-1:0]  r_out_used,   n_out_used;

    // ------------------------------------------------------------------
    // Bitmap memory and shared word unit
    // ------------------------------------------------------------------
    logic                     ram_we;
    logic [MAP_WORD_BITS-1:0] ram_wdata;
    logic [MAP_WORD_BITS-1:0] ram_rdata;

    logic [MAP_WORD_BITS-1:0] wu_new;
    logic [PW-1:0]            wu_flips;
    logic                     wu_found;
    logic [BIW-1:0]           wu_bit;

    bfa_map_ram #(
        .WORDS  (MAP_WORDS),
        .WIDTH  (MAP_WORD_BITS),
        .ADDR_W (WIW)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_word),
        .i_wdata (ram_wdata),
        .i_raddr (r_word),
        .o_rdata (ram_rdata)
    );

    bfa_word_unit #(
        .MAP_WORD_BITS (MAP_WORD_BITS),
        .KW            (KW)
    ) u_word_unit (
        .i_op    (r_op),
        .i_old   (ram_rdata),
        .i_base  (r_base),
        .i_first (r_first),
        .i_end   (r_end),
        .o_new   (wu_new),
        .o_flips (wu_flips),
        .o_found (wu_found),
        .o_bit   (wu_bit)
    );

    // Fill pass writes all ones; the modify step writes back the unit's word
    assign ram_we    = (r_state == ST_CLEAR) || (r_state == ST_MOD);
    assign ram_wdata = (r_state == ST_CLEAR) ? '1 : wu_new;

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    logic [CW-1:0]    req_first;
    logic [CW-1:0]    req_end;
    logic [CW-1:0]    tot_c;
    logic [PRW-1:0]   div_prod;
    logic [WIW-1:0]   div_q;
    logic [CNT_W-1:0] cfg_total;
    logic             more_words;

    assign req_first = CW'(i_req.byte_address >> PAGE_SHIFT);
    assign req_end   = req_first + CW'(i_req.region_bytes >> PAGE_SHIFT);
    assign tot_c     = CW'(r_total);

    assign div_prod  = PRW'(r_first) * PRW'(RM);
    assign div_q     = div_prod[RS +: WIW];

    assign cfg_total = (32'(i_cfg_wdata) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES)
                                                             : i_cfg_wdata;

    // Range continues past the current word
    assign more_words = (KW+1)'(r_end) > ((KW+1)'(r_base) + (KW+1)'(MAP_WORD_BITS));

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state  = r_state;
        n_word   = r_word;
        n_hint   = r_hint;
        n_base   = r_base;
        n_first  = r_first;
        n_end    = r_end;
        n_op     = r_op;
        n_pin    = r_pin;
        n_status = r_status;
        n_faddr  = r_faddr;
        n_total  = r_total;
        n_used   = r_used;

        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_faddr  = r_out_faddr;
        n_out_free   = r_out_free;
        n_out_used   = r_out_used;

        i_req.ready = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                // Mark one word used per cycle
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_word = r_word + 1'b1;
                end
            end

            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_status = STS_OK;
                    n_faddr  = '0;
                    n_pin    = 1'b0;
                    case (t_req'(i_req.req_type))
                        REQ_ALLOC: begin
                            if (r_used < r_total) begin
                                n_op    = WOP_SCAN;
                                n_word  = r_hint;
                                n_state = ST_READ;
                            end else begin
                                n_status = STS_OOM;
                                n_state  = ST_DONE;
                            end
                        end
                        REQ_FREE: begin
                            if (req_first >= tot_c) begin
                                n_status = STS_RANGE;
                                n_state  = ST_DONE;
                            end else begin
                                n_first = CNT_W'(req_first);
                                n_end   = CNT_W'(req_first) + 1'b1;
                                n_op    = WOP_CLR;
                                n_state = ST_DIV;
                            end
                        end
                        REQ_RELEASE, REQ_RESERVE: begin
                            if (req_first >= tot_c) begin
                                n_status = STS_RANGE;
                                n_state  = ST_DONE;
                            end else begin
                                n_first = CNT_W'(req_first);
                                // Clip a region that runs past the managed frames
                                if (req_end > tot_c) begin
                                    n_end    = r_total;
                                    n_status = STS_RANGE;
                                end else begin
                                    n_end = CNT_W'(req_end);
                                end
                                if (t_req'(i_req.req_type) == REQ_RESERVE) begin
                                    n_op = WOP_SET;
                                end else begin
                                    n_op  = WOP_CLR;
                                    n_pin = 1'b1;
                                end
                                n_state = ST_DIV;
                            end
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_DIV: begin
                // Start word of the range
                n_word  = div_q;
                n_state = ST_READ;
            end

            ST_READ: begin
                // Memory read of r_word is in flight; fetch its first frame
                n_base  = KW'(r_word) * KW'(MAP_WORD_BITS);
                n_state = ST_MOD;
            end

            ST_MOD: begin
                if (r_op == WOP_CLR) begin
                    n_used = r_used - CNT_W'(wu_flips);
                    if (r_word < r_hint) begin
                        n_hint = r_word;
                    end
                end else begin
                    n_used = r_used + CNT_W'(wu_flips);
                end

                if (r_op == WOP_SCAN) begin
                    if (wu_found) begin
                        n_faddr = 32'(r_base + KW'(wu_bit)) << PAGE_SHIFT;
                        n_hint  = r_word;
                        n_state = ST_DONE;
                    end else begin
                        n_word  = r_word + 1'b1;
                        n_state = ST_READ;
                    end
                end else if (more_words) begin
                    n_word  = r_word + 1'b1;
                    n_state = ST_READ;
                end else if (r_pin) begin
                    // Keep frame 0 reserved after a region release
                    n_pin   = 1'b0;
                    n_first = '0;
                    n_end   = CNT_W'(1);
                    n_op    = WOP_SET;
                    n_word  = '0;
                    n_state = ST_READ;
                end else begin
                    n_state = ST_DONE;
                end
            end

            ST_DONE: begin
                // Hold until the result register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_faddr  = r_faddr;
                    n_out_free   = r_total - r_used;
                    n_out_used   = r_used;
                    n_state      = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_CLEAR;
                n_word  = '0;
            end
        endcase

        // A frame count write marks all frames used and restarts the fill pass
        if (i_cfg_we) begin
            n_total = cfg_total;
            n_used  = cfg_total;
            n_hint  = '0;
            n_word  = '0;
            n_state = ST_CLEAR;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_word      <= '0;
            r_hint      <= '0;
            r_total     <= '0;
            r_used      <= '0;
            r_pin       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_hint      <= n_hint;
            r_total     <= n_total;
            r_used      <= n_used;
            r_pin       <= n_pin;
            r_out_valid <= n_out_valid;
        end
        r_base       <= n_base;
        r_first      <= n_first;
        r_end        <= n_end;
        r_op         <= n_op;
        r_status     <= n_status;
        r_faddr      <= n_faddr;
        r_out_status <= n_out_status;
        r_out_faddr  <= n_out_faddr;
        r_out_free   <= n_out_free;
        r_out_used   <= n_out_used;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.frame_address = r_out_faddr;
    assign o_rsp.free_frames   = r_out_free;
    assign o_rsp.used_frames   = r_out_used;

`ifndef SYNTHESIS
    // The used count never exceeds the managed frame count
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_total)
        else $error("used frame count above total frames");

    // One item at a time: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("item accepted while previous item in work");

    // Failed requests never return a frame address
    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != STS_OK)) |-> (o_rsp.frame_address == '0))
        else $error("nonzero frame address on failed request");
`endif

endmodule

/* bench/bfa_checker.sv */
// ----------------------------------------------------------------------------
// bfa_checker
// Watches the request, result and register ports of the frame allocator, keeps
// its own copy of the used map and counts, and compares every result with the
// oldest one owed.
// ----------------------------------------------------------------------------
module bfa_checker import bfa_pkg::*; #(
    parameter int MAX_FRAMES    = 32768,
    parameter int PAGE_SHIFT    = 12,
    parameter int MAP_WORD_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_wdata,
    bfa_req_if               req_mon,
    bfa_rsp_if               rsp_mon,
    output int               o_fail_count,
    output int               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        t_status           status;
        logic [ADDR_W-1:0] frame_address;
        logic [CNT_W-1:0]  free_frames;
        logic [CNT_W-1:0]  used_frames;
    } t_frame_result;

    bit [MAP_WORD_BITS-1:0] frame_map [MAP_WORDS];
    int unsigned            used_total;
    int unsigned            frame_limit;
    t_frame_result          owed_results[$];
    int                     mismatch_total = 0;

    function automatic void fill_map();
        foreach (frame_map[w])
            frame_map[w] = '1;
    endfunction

    // Flip one frame and keep the count in step; no change, no count update.
    function automatic void mark_frame(int unsigned f, bit used);
        if (frame_map[f / MAP_WORD_BITS][f % MAP_WORD_BITS] != used) begin
            frame_map[f / MAP_WORD_BITS][f % MAP_WORD_BITS] = used;
            if (used)
                used_total++;
            else
                used_total--;
        end
    endfunction

    function automatic void load_frame_count(logic [CNT_W-1:0] value);
        frame_limit = (value > MAX_FRAMES) ? MAX_FRAMES : value;
        fill_map();
        used_total = frame_limit;
    endfunction

    function automatic t_frame_result serve_request(t_req kind, logic [ADDR_W-1:0] addr,
                                                    logic [ADDR_W-1:0] len_bytes);
        t_frame_result     res;
        int unsigned       first;
        longint unsigned   stop;
        bit                found;
        res.status        = STS_OK;
        res.frame_address = '0;
        first             = addr >> PAGE_SHIFT;
        found             = 1'b0;
        case (kind)
            REQ_ALLOC: begin
                // Frames past the count always read as used, so the lowest
                // clear bit is the first-fit frame.
                if (used_total < frame_limit) begin
                    for (int w = 0; w < MAP_WORDS && !found; w++) begin
                        if (frame_map[w] != '1) begin
                            for (int j = 0; j < MAP_WORD_BITS && !found; j++) begin
                                if (!frame_map[w][j] && w * MAP_WORD_BITS + j < frame_limit) begin
                                    mark_frame(w * MAP_WORD_BITS + j, 1'b1);
                                    res.frame_address = (w * MAP_WORD_BITS + j) << PAGE_SHIFT;
                                    found = 1'b1;
                                end
                            end
                        end
                    end
                end
                if (!found)
                    res.status = STS_OOM;
            end
            REQ_FREE: begin
                if (first >= frame_limit)
                    res.status = STS_RANGE;
                else
                    mark_frame(first, 1'b0);
            end
            default: begin
                stop = longint'(first) + longint'(len_bytes >> PAGE_SHIFT);
                if (first >= frame_limit) begin
                    res.status = STS_RANGE;
                end else begin
                    if (stop > frame_limit) begin
                        stop       = frame_limit;
                        res.status = STS_RANGE;
                    end
                    for (longint unsigned f = first; f < stop; f++)
                        mark_frame(32'(f), kind == REQ_RESERVE);
                    // A release always leaves frame 0 pinned
                    if (kind == REQ_RELEASE)
                        mark_frame(0, 1'b1);
                end
            end
        endcase
        res.free_frames = CNT_W'(frame_limit - used_total);
        res.used_frames = CNT_W'(used_total);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_frame_result want;
        if (!i_rst_n) begin
            fill_map();
            used_total  = 0;
            frame_limit = 0;
            owed_results.delete();
        end else begin
            if (i_cfg_we)
                load_frame_count(i_cfg_wdata);
            if (req_mon.valid && req_mon.ready)
                owed_results.push_back(serve_request(t_req'(req_mon.req_type),
                                                     req_mon.byte_address,
                                                     req_mon.region_bytes));
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (owed_results.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= MAX_REPORTS)
                        $display("%0t: unowed result: status %0d addr %h free %0d used %0d",
                                 $realtime, rsp_mon.status, rsp_mon.frame_address,
                                 rsp_mon.free_frames, rsp_mon.used_frames);
                end else begin
                    want = owed_results.pop_front();
                    if (rsp_mon.status !== want.status
                            || rsp_mon.frame_address !== want.frame_address
                            || rsp_mon.free_frames !== want.free_frames
                            || rsp_mon.used_frames !== want.used_frames) begin
                        mismatch_total++;
                        if (mismatch_total <= MAX_REPORTS) begin
                            $display("%0t: result mismatch (expected/actual):", $realtime);
                            $display("    status %0d/%0d addr %h/%h free %0d/%0d used %0d/%0d",
                                     want.status, rsp_mon.status,
                                     want.frame_address, rsp_mon.frame_address,
                                     want.free_frames, rsp_mon.free_frames,
                                     want.used_frames, rsp_mon.used_frames);
                        end
                    end
                end
            end
        end
        o_pending    = owed_results.size();
        o_fail_count = mismatch_total;
    end

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Top of the frame allocator bench: drives register writes and requests
// through a directed pass and random passes under varying back-pressure,
// and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int MAX_FRAMES  = 32768;
    localparam int PAGE_SHIFT  = 12;
    localparam int PAGE_BYTES  = 1 << PAGE_SHIFT;
    // Slowest quiet gap: a fill pass plus a full-map region, a long receiver
    // hold-off and random stalls, taken several times over.
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();

    int mismatch_total;
    int results_owed;

    // Idle rates in percent, the frame count currently loaded, and the
    // request for one long receiver hold-off.
    int unsigned send_idle_pct = 12;
    int unsigned recv_idle_pct = 53;
    int unsigned cur_frames    = 0;
    bit          hold_off_req  = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    bitmap_frame_allocator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_ch.sink),
        .o_rsp       (rsp_ch.source)
    );

    bfa_checker #(
        .MAX_FRAMES    (MAX_FRAMES),
        .PAGE_SHIFT    (PAGE_SHIFT),
        .MAP_WORD_BITS (32)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .o_fail_count (mismatch_total),
        .o_pending    (results_owed)
    );

    // Result side: random stalls at the current rate, plus one long hold-off
    // on request so the block fills up and stalls its input.
    initial begin
        int unsigned stall_left;
        bit          hold_off_taken;
        stall_left     = 0;
        hold_off_taken = 1'b0;
        rsp_ch.ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req && !hold_off_taken) begin
                hold_off_taken = 1'b1;
                stall_left     = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run once nothing has been accepted for too long.
    initial begin
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("bitmap_frame_allocator test failed");
        $finish;
    end

    // Offer one item, with random idle cycles first; return once accepted.
    task automatic push_request(t_req kind, logic [ADDR_W-1:0] addr,
                                logic [ADDR_W-1:0] len_bytes);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.byte_address <= addr;
        req_ch.region_bytes <= len_bytes;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    // Drop valid and hold until every owed result has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (results_owed != 0)
            @(negedge i_clk);
    endtask

    // Load a new frame count while the block is idle; it refills the map.
    task automatic write_frame_count(logic [CNT_W-1:0] value);
        wait_for_results();
        repeat (4) @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge i_clk);
        cfg_we     <= 1'b0;
        cur_frames  = (value > MAX_FRAMES) ? MAX_FRAMES : value;
    endtask

    // Mostly well-formed traffic within the managed range; the rest is noise
    // with every field fully random.
    task automatic push_random_request();
        int unsigned       roll;
        int unsigned       first;
        int unsigned       span;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len_bytes;
        roll      = $urandom_range(0, 99);
        addr      = $urandom;
        len_bytes = $urandom;
        if (roll < 35) begin
            push_request(REQ_ALLOC, addr, len_bytes);
        end else if (roll < 60) begin
            // A few land past the count
            first = $urandom_range(0, cur_frames + cur_frames / 16);
            push_request(REQ_FREE, (first << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1),
                         len_bytes);
        end else if (roll < 84) begin
            first = $urandom_range(0, cur_frames - 1);
            if (roll < 72)
                span = $urandom_range(0, cur_frames - first + 1);
            else
                span = $urandom_range(0, 6);
            push_request(roll < 72 ? REQ_RELEASE : REQ_RESERVE,
                         (first << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1),
                         (span << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1));
        end else begin
            push_request(t_req'($urandom_range(0, 3)), addr, len_bytes);
        end
    endtask

    task automatic run_random(int count, bit with_pressure);
        for (int n = 0; n < count; n++) begin
            if (with_pressure && n == count / 3)
                hold_off_req = 1'b1;
            if (with_pressure && n == 2 * count / 3)
                wait_for_results();
            push_random_request();
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_ALLOC;
        req_ch.byte_address = '0;
        req_ch.region_bytes = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily
        send_idle_pct = 12;
        recv_idle_pct = 53;

        // No frames managed after reset: everything fails
        push_request(REQ_ALLOC, 32'h0, 32'h0);
        push_request(REQ_RELEASE, 32'h0, 32'h0);

        write_frame_count(64);
        push_request(REQ_ALLOC, 32'h0, 32'h0);                 // map full
        push_request(REQ_RELEASE, 32'h0, 32'hFFFF_FFFF);       // runs past count
        push_request(REQ_ALLOC, 32'h0, 32'h0);                 // frame 1, frame 0 pinned
        push_request(REQ_FREE, 32'h0, 32'h0);                  // unpin frame 0
        push_request(REQ_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // frame 0, address 0
        push_request(REQ_FREE, 32'h0000_5FFF, 32'h0);          // frame 5, offset ignored
        push_request(REQ_FREE, 32'h0000_5000, 32'h0);          // already free
        push_request(REQ_FREE, 64 << PAGE_SHIFT, 32'h0);       // first frame past count
        push_request(REQ_FREE, 32'hFFFF_FFFF, 32'h0);
        push_request(REQ_RESERVE, 60 << PAGE_SHIFT, 10 << PAGE_SHIFT);
        push_request(REQ_RELEASE, 60 << PAGE_SHIFT, 32'h0);    // empty release
        push_request(REQ_RESERVE, 32'hFFFF_F000, 32'hFFFF_FFFF);
        push_request(REQ_RELEASE, 64 << PAGE_SHIFT, PAGE_BYTES);
        push_request(REQ_RESERVE, 32'h0000_2000, 32'h0000_3FFF);
        push_request(REQ_RELEASE, 32'h0000_2000, PAGE_BYTES);
        push_request(REQ_RESERVE, 32'h0, 64 << PAGE_SHIFT);
        push_request(REQ_ALLOC, 32'h0, 32'h0);                 // out of memory
        push_request(REQ_RELEASE, 63 << PAGE_SHIFT, PAGE_BYTES);
        push_request(REQ_ALLOC, 32'h0, 32'h0);                 // last frame

        // Single frame: only frame 0 exists
        write_frame_count(1);
        push_request(REQ_ALLOC, 32'h0, 32'h0);
        push_request(REQ_RELEASE, 32'h0, PAGE_BYTES);
        push_request(REQ_FREE, 32'h0, 32'h0);
        push_request(REQ_ALLOC, 32'h0, 32'h0);

        // Top of the register range saturates to the full map
        write_frame_count(16'hFFFF);
        push_request(REQ_RELEASE, 32'h0, 32'hFFFF_FFFF);
        push_request(REQ_FREE, (MAX_FRAMES - 1) << PAGE_SHIFT, 32'h0);
        push_request(REQ_RESERVE, (MAX_FRAMES - 1) << PAGE_SHIFT, PAGE_BYTES);
        push_request(REQ_RESERVE, 32'h0, MAX_FRAMES << PAGE_SHIFT);
        push_request(REQ_ALLOC, 32'h0, 32'h0);

        write_frame_count(96);
        run_random(450, 1'b0);

        // Swap the idle rates
        write_frame_count(256);
        send_idle_pct = 53;
        recv_idle_pct = 12;
        run_random(450, 1'b0);

        // No idling; a count that ends mid-word, with the long hold-off and
        // a full drain in the middle
        write_frame_count(33);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(350, 1'b1);

        write_frame_count(1000);
        run_random(300, 1'b0);

        wait_for_results();
        repeat (20) @(negedge i_clk);
        if (mismatch_total == 0 && results_owed == 0)
            $display("bitmap_frame_allocator test passed");
        else
            $display("bitmap_frame_allocator test failed");
        $finish;
    end

endmodule
